>>> hw/rtl/i2cs_pkg.sv
// Shared types, codes and beat layouts for the I2C master transfer sequencer.
`timescale 1ns / 1ps

package i2cs_pkg;

  localparam int unsigned DefCountWidth = 16;
  localparam int unsigned InDataWidth   = 64;
  localparam int unsigned InUserWidth   = 1;
  localparam int unsigned OutDataWidth  = 32;

  // Item kind carried in tuser.
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_EVENT = 1'b1
  } action_t;

  // Engine flag control codes (START and acknowledge).
  typedef enum logic [1:0] {
    CTL_NONE  = 2'd0,
    CTL_SET   = 2'd1,
    CTL_CLEAR = 2'd2
  } ctl_t;

  // Standard master status codes handled by the sequencer.
  typedef enum logic [7:0] {
    ST_START       = 8'h08,
    ST_RESTART     = 8'h10,
    ST_SLA_W_ACK   = 8'h18,
    ST_DATA_W_ACK  = 8'h28,
    ST_SLA_R_ACK   = 8'h40,
    ST_DATA_R_ACK  = 8'h50,
    ST_DATA_R_NACK = 8'h58
  } status_t;

  // Input item: action from tuser on top, tdata fields below (last field lowest).
  typedef struct packed {
    logic       action;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic [7:0] status_code;
    logic [15:0] byte_count;
    logic [7:0] register_index;
    logic [7:0] slave_address;
    logic       read_request;
  } in_item_t;

  localparam int unsigned InPackWidth  = $bits(in_item_t) - 1;
  localparam int unsigned InPadWidth   = InDataWidth - InPackWidth;

  // Result item, last field lowest.
  typedef struct packed {
    logic       unexpected;
    logic       op_done;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       clear_irq;
    logic [1:0] ack_ctl;
    logic       stop_set;
    logic [1:0] start_ctl;
    logic       tx_taken;
    logic [7:0] send_data;
    logic       send_valid;
  } result_t;

  localparam int unsigned OutPadWidth = OutDataWidth - $bits(result_t);

  // Latched transfer context.
  typedef struct packed {
    logic [7:0] address_byte;
    logic [7:0] register_byte;
  } ctx_t;

endpackage

>>> hw/rtl/i2cs_in_reg.sv
// Input register stage with a valid flag and downstream-driven advance.
`timescale 1ns / 1ps

module i2cs_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_valid,
  output logic               s_ready,
  input  i2cs_pkg::in_item_t s_item,
  input  logic               take,
  output logic               valid,
  output i2cs_pkg::in_item_t item
);
  import i2cs_pkg::*;

  // Refill in the same cycle the held item moves on.
  assign s_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

>>> hw/rtl/i2cs_decode.sv
// Status decode: one item plus current context gives one result and the next context.
`timescale 1ns / 1ps

module i2cs_decode #(
  parameter int unsigned COUNT_WIDTH = i2cs_pkg::DefCountWidth
) (
  input  i2cs_pkg::in_item_t     item,
  input  i2cs_pkg::ctx_t         ctx,
  input  logic [COUNT_WIDTH-1:0] count,
  output i2cs_pkg::result_t      res,
  output i2cs_pkg::ctx_t         ctx_next,
  output logic [COUNT_WIDTH-1:0] count_next
);
  import i2cs_pkg::*;

  logic [COUNT_WIDTH-1:0] count_dec;
  logic                   count_nz;

  // Saturating decrement.
  assign count_nz  = (count != '0);
  assign count_dec = count_nz ? (count - COUNT_WIDTH'(1)) : count;

  function automatic logic [1:0] ack_of(input logic [COUNT_WIDTH-1:0] c);
    return (c >= COUNT_WIDTH'(2)) ? CTL_SET : CTL_CLEAR;
  endfunction

  always_comb begin
    res        = '0;
    ctx_next   = ctx;
    count_next = count;
    if (item.action == ACT_START) begin
      ctx_next.address_byte  = {item.slave_address[7:1], item.read_request};
      ctx_next.register_byte = item.register_index;
      count_next             = COUNT_WIDTH'(item.byte_count);
      res.start_ctl          = CTL_SET;
    end else begin
      res.clear_irq = 1'b1;
      unique case (item.status_code)
        ST_START: begin
          res.send_valid = 1'b1;
          res.send_data  = {ctx.address_byte[7:1], 1'b0};
        end
        ST_RESTART: begin
          res.send_valid = 1'b1;
          res.send_data  = ctx.address_byte;
        end
        ST_SLA_W_ACK: begin
          res.start_ctl  = CTL_CLEAR;
          res.send_valid = 1'b1;
          res.send_data  = ctx.register_byte;
        end
        ST_DATA_W_ACK: begin
          if (ctx.address_byte[0]) begin
            res.start_ctl = CTL_SET;        // repeated start into read phase
          end else if (count_nz) begin
            res.send_valid = 1'b1;
            res.send_data  = item.tx_byte;
            res.tx_taken   = 1'b1;
            count_next     = count_dec;
          end else begin
            res.stop_set = 1'b1;
            res.op_done  = 1'b1;
          end
        end
        ST_SLA_R_ACK: begin
          res.start_ctl = CTL_CLEAR;
          res.ack_ctl   = ack_of(count);
        end
        ST_DATA_R_ACK: begin
          res.rx_valid = 1'b1;
          res.rx_data  = item.rx_byte;
          count_next   = count_dec;
          res.ack_ctl  = ack_of(count_dec);
        end
        ST_DATA_R_NACK: begin
          res.rx_valid = 1'b1;
          res.rx_data  = item.rx_byte;
          count_next   = count_dec;
          res.stop_set = 1'b1;
          res.ack_ctl  = CTL_SET;
          res.op_done  = 1'b1;
        end
        default: begin
          res.stop_set   = 1'b1;
          res.unexpected = 1'b1;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/i2c_master_register_transfer_sequencer.sv
// Top level of the I2C master register transfer sequencer.
`timescale 1ns / 1ps

// Usage
// -----
// Slave channel (s_axis_*): one beat per item. tuser[0] is the action:
// 0 starts a transfer (latches address with direction bit, register index
// and byte count), 1 reports an engine status event. Event beats carry the
// status code, the byte received by the engine and the next write byte.
// Master channel (m_axis_*): exactly one result beat per input beat, in
// order, holding the engine commands (byte to send, START/ack control,
// STOP, irq clear), a received byte for the consumer and done/unexpected.
// Timing: an accepted beat is held in the input register, is decoded
// against the transfer context and lands in the result register once that
// register is free. Both stages are registered, and a low m_axis_tready
// can hold a beat in either. One beat per cycle is sustained while
// m_axis_tready stays high; the pace is set by the single decode stage and
// the context registers, updated as each item leaves the input register.
// Stalls: when m_axis_tready is low the result register holds, the input
// register fills, then s_axis_tready drops; nothing is dropped or repeated.
// Reset (rst, synchronous): empties both stages and clears the address,
// register and remaining count.

module i2c_master_register_transfer_sequencer #(
  parameter int unsigned COUNT_WIDTH = i2cs_pkg::DefCountWidth
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] read_request, [8:1] slave_address, [16:9] register_index,
  // [32:17] byte_count, [40:33] status_code, [48:41] rx_byte,
  // [56:49] tx_byte, [63:57] zero
  input  logic [i2cs_pkg::InDataWidth-1:0]   s_axis_tdata,
  // [0] action
  input  logic [i2cs_pkg::InUserWidth-1:0]   s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] send_valid, [8:1] send_data, [9] tx_taken, [11:10] start_ctl,
  // [12] stop_set, [14:13] ack_ctl, [15] clear_irq, [16] rx_valid,
  // [24:17] rx_data, [25] op_done, [26] unexpected, [31:27] zero
  output logic [i2cs_pkg::OutDataWidth-1:0]  m_axis_tdata
);
  import i2cs_pkg::*;

  in_item_t               s_item;
  in_item_t               item;
  logic                   item_valid;
  logic                   out_free;
  logic                   advance;

  ctx_t                   ctx;
  ctx_t                   ctx_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  result_t                dec_res;
  result_t                res;

  assign s_item = {s_axis_tuser[0], s_axis_tdata[InPackWidth-1:0]};

  // Result register frees up when empty or being drained this cycle.
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign advance  = item_valid && out_free;

  i2cs_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_item  (s_item),
    .take    (advance),
    .valid   (item_valid),
    .item    (item)
  );

  i2cs_decode #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_decode (
    .item       (item),
    .ctx        (ctx),
    .count      (count),
    .res        (dec_res),
    .ctx_next   (ctx_next),
    .count_next (count_next)
  );

  // Transfer context: committed only when the item moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx   <= '0;
      count <= '0;
    end else if (advance) begin
      ctx   <= ctx_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= dec_res;
    end
  end

  assign m_axis_tdata = {{OutPadWidth{1'b0}}, res};

`ifndef SYNTHESIS
  // Received byte and byte to send never share one result.
  a_rx_send_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(res.rx_valid && res.send_valid))
    else $error("rx_valid and send_valid both set");

  // Consuming write data always means sending it.
  a_tx_implies_send: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.tx_taken |-> res.send_valid)
    else $error("tx_taken without send_valid");

  // Done and unknown-status both end with STOP, never together.
  a_end_stop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (res.op_done || res.unexpected)
      |-> res.stop_set && !(res.op_done && res.unexpected))
    else $error("done/unexpected without STOP or both set");

  // A start item loads the count from its byte count.
  a_start_load: assert property (@(posedge clk) disable iff (rst)
    advance && item.action == ACT_START
      |=> count == COUNT_WIDTH'($past(item.byte_count)))
    else $error("count not loaded on start");

  // Count only changes when an item moves on.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(count))
    else $error("count changed without an item");
`endif

endmodule

>>> test/testbench.sv
// Self-checking stream testbench for the I2C master register transfer sequencer.
`timescale 1ns / 1ps

module testbench;
  import i2cs_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int RandomTarget = 1325;  // least total of beats queued, directed part included
  localparam int QuietTail    = 150;   // last beats go out with no idling on either side
  localparam int ResWidth     = $bits(result_t);

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_valid = 1'b0;
  logic                    s_ready;
  logic [InDataWidth-1:0]  s_data = '0;
  logic [InUserWidth-1:0]  s_user = '0;
  logic                    m_valid;
  logic                    m_ready = 1'b0;
  logic [OutDataWidth-1:0] m_data;

  // Stimulus waiting to be driven and command words waiting to come out.
  in_item_t pending_beats[$];
  result_t  expected_commands[$];

  int cycles         = 0;
  int beats_accepted = 0;
  int total_beats    = 0;
  int results_seen   = 0;
  int mismatches     = 0;

  // Transfer context as the block should hold it.
  logic [7:0]  ctx_address   = '0;
  logic [7:0]  ctx_register  = '0;
  logic [15:0] ctx_remaining = '0;

  i2c_master_register_transfer_sequencer DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Command prediction: one command word per beat, context updated in place.
  // ---------------------------------------------------------------------------
  function automatic logic [1:0] ack_for_remaining();
    return (ctx_remaining >= 16'd2) ? CTL_SET : CTL_CLEAR;
  endfunction

  function automatic result_t predict_commands(in_item_t it);
    result_t r;
    r = '0;
    if (it.action == ACT_START) begin
      // Direction replaces the address LSB: odd for read, even for write.
      ctx_address   = it.read_request ? (it.slave_address | 8'h01)
                                      : (it.slave_address & 8'hFE);
      ctx_register  = it.register_index;
      ctx_remaining = it.byte_count;
      r.start_ctl   = CTL_SET;
      return r;
    end
    r.clear_irq = 1'b1;
    case (it.status_code)
      ST_START: begin
        r.send_valid = 1'b1;
        r.send_data  = ctx_address & 8'hFE;
      end
      ST_RESTART: begin
        r.send_valid = 1'b1;
        r.send_data  = ctx_address;
      end
      ST_SLA_W_ACK: begin
        r.start_ctl  = CTL_CLEAR;
        r.send_valid = 1'b1;
        r.send_data  = ctx_register;
      end
      ST_DATA_W_ACK: begin
        if (ctx_address[0]) begin
          r.start_ctl = CTL_SET;  // repeated start for the read phase
        end else if (ctx_remaining != 0) begin
          r.send_valid  = 1'b1;
          r.send_data   = it.tx_byte;
          r.tx_taken    = 1'b1;
          ctx_remaining = ctx_remaining - 16'd1;
        end else begin
          r.stop_set = 1'b1;
          r.op_done  = 1'b1;
        end
      end
      ST_SLA_R_ACK: begin
        r.start_ctl = CTL_CLEAR;
        r.ack_ctl   = ack_for_remaining();
      end
      ST_DATA_R_ACK: begin
        r.rx_valid = 1'b1;
        r.rx_data  = it.rx_byte;
        if (ctx_remaining != 0) ctx_remaining = ctx_remaining - 16'd1;  // saturates at zero
        r.ack_ctl = ack_for_remaining();
      end
      ST_DATA_R_NACK: begin
        r.rx_valid = 1'b1;
        r.rx_data  = it.rx_byte;
        if (ctx_remaining != 0) ctx_remaining = ctx_remaining - 16'd1;
        r.stop_set = 1'b1;
        r.ack_ctl  = CTL_SET;
        r.op_done  = 1'b1;
      end
      default: begin
        r.stop_set   = 1'b1;
        r.unexpected = 1'b1;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders. Fields the block ignores for a kind are left random.
  // ---------------------------------------------------------------------------
  function automatic in_item_t random_item();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t start_beat(logic rd, logic [7:0] addr, logic [7:0] ridx,
                                          logic [15:0] cnt);
    in_item_t it;
    it                = random_item();
    it.action         = ACT_START;
    it.read_request   = rd;
    it.slave_address  = addr;
    it.register_index = ridx;
    it.byte_count     = cnt;
    return it;
  endfunction

  function automatic in_item_t event_beat(logic [7:0] status);
    in_item_t it;
    it             = random_item();
    it.action      = ACT_EVENT;
    it.status_code = status;
    return it;
  endfunction

  // Well-formed transfer with random content; broken ones are cut short and may
  // end in a stray status.
  task automatic queue_transfer(logic rd, logic broken);
    in_item_t seq[$];
    int       count;
    int       data_beats;
    int       cut;
    count      = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5);
    data_beats = (count > 6) ? $urandom_range(0, 6) : count;
    seq.push_back(start_beat(rd, 8'($urandom), 8'($urandom), 16'(count)));
    seq.push_back(event_beat(ST_START));
    seq.push_back(event_beat(ST_SLA_W_ACK));
    if (rd) begin
      seq.push_back(event_beat(ST_DATA_W_ACK));
      seq.push_back(event_beat(ST_RESTART));
      seq.push_back(event_beat(ST_SLA_R_ACK));
      for (int i = 1; i < data_beats; i++) seq.push_back(event_beat(ST_DATA_R_ACK));
      seq.push_back(event_beat(ST_DATA_R_NACK));
    end else begin
      for (int i = 0; i < data_beats; i++) seq.push_back(event_beat(ST_DATA_W_ACK));
      seq.push_back(event_beat(ST_DATA_W_ACK));  // closes with STOP when the count ran out
    end
    if (broken) begin
      cut = $urandom_range(1, seq.size() - 1);
      seq = seq[0:cut-1];
      if ($urandom_range(0, 1)) seq.push_back(event_beat(8'($urandom)));
    end
    foreach (seq[i]) pending_beats.push_back(seq[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int pick;
    // Directed: status before any start, full write and read flows with extreme
    // bytes, count saturation, unknown codes, largest and zero counts.
    pending_beats.push_back(event_beat(ST_START));
    pending_beats.push_back(start_beat(1'b0, 8'hFF, 8'h00, 16'd2));
    pending_beats.push_back(event_beat(ST_START));
    pending_beats.push_back(event_beat(ST_SLA_W_ACK));
    pending_beats.push_back(event_beat(ST_DATA_W_ACK));
    pending_beats.push_back(event_beat(ST_DATA_W_ACK));
    pending_beats.push_back(event_beat(ST_DATA_W_ACK));
    pending_beats.push_back(start_beat(1'b1, 8'h00, 8'hFF, 16'd3));
    pending_beats.push_back(event_beat(ST_START));
    pending_beats.push_back(event_beat(ST_SLA_W_ACK));
    pending_beats.push_back(event_beat(ST_DATA_W_ACK));
    pending_beats.push_back(event_beat(ST_RESTART));
    pending_beats.push_back(event_beat(ST_SLA_R_ACK));
    pending_beats.push_back(event_beat(ST_DATA_R_ACK));
    pending_beats.push_back(event_beat(ST_DATA_R_ACK));
    pending_beats.push_back(event_beat(ST_DATA_R_NACK));
    pending_beats.push_back(event_beat(ST_DATA_R_ACK));   // count already zero
    pending_beats.push_back(event_beat(ST_DATA_R_NACK));  // still zero
    pending_beats.push_back(event_beat(8'hFF));
    pending_beats.push_back(event_beat(8'h00));
    pending_beats.push_back(start_beat(1'b1, 8'h5A, 8'hA5, 16'hFFFF));
    pending_beats.push_back(event_beat(ST_SLA_R_ACK));
    pending_beats.push_back(event_beat(ST_DATA_R_ACK));
    pending_beats.push_back(start_beat(1'b0, 8'h81, 8'h7E, 16'd0));
    pending_beats.push_back(event_beat(ST_DATA_W_ACK));

    // Random: mostly clean transfers, some broken ones, some pure noise.
    while (pending_beats.size() < RandomTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) queue_transfer(1'($urandom_range(0, 1)), 1'b0);
      else if (pick < 85) queue_transfer(1'($urandom_range(0, 1)), 1'b1);
      else if (pick < 92) pending_beats.push_back(random_item());
      else pending_beats.push_back(event_beat(8'($urandom)));
    end
    total_beats = pending_beats.size();

    while (beats_accepted < total_beats) @(posedge clk);
    while (expected_commands.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);  // room for a stray extra beat to show up
    foreach (expected_commands[i]) begin
      $display("%0t: missing result, expected %h actual none", $time, expected_commands[i]);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS i2c_master_register_transfer_sequencer");
    end else begin
      $display("FAIL i2c_master_register_transfer_sequencer");
    end
    $finish;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL i2c_master_register_transfer_sequencer");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offers beats from the pending queue, random idle bursts whose rate
  // changes with the phase of the cycle counter (one phase has none at all).
  // ---------------------------------------------------------------------------
  in_item_t drive_item;
  int       send_gap = 0;

  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      next_valid = s_valid;
      if (s_valid && s_ready) begin
        expected_commands.push_back(predict_commands(drive_item));
        beats_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_beats.size() != 0) begin
          if (pending_beats.size() >= QuietTail &&
              $urandom_range(0, 99) < ((cycles >> 7) % 3) * 15) begin
            send_gap = $urandom_range(0, 4);
          end else begin
            drive_item = pending_beats.pop_front();
            s_data     <= InDataWidth'(drive_item[InPackWidth-1:0]);
            s_user     <= drive_item.action;
            next_valid = 1'b1;
          end
        end
      end
      s_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Sink: random backpressure bursts, plus one long hold once traffic is
  // flowing so both stages fill and s_axis_tready drops.
  // ---------------------------------------------------------------------------
  int   sink_gap  = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 250;
      m_ready   <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_ready  <= 1'b0;
    end else if (pending_beats.size() >= QuietTail &&
                 $urandom_range(0, 99) < (((cycles >> 7) + 1) % 3) * 15) begin
      sink_gap <= $urandom_range(0, 4);
      m_ready  <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result beat against the oldest prediction, field by field.
  // ---------------------------------------------------------------------------
  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_valid && m_ready) begin
      results_seen++;
      got = m_data[ResWidth-1:0];
      check_field("pad", '0, 16'(m_data[OutDataWidth-1:ResWidth]));
      if (expected_commands.size() == 0) begin
        $display("%0t: extra result, expected none actual %h", $time, got);
        mismatches++;
      end else begin
        want = expected_commands.pop_front();
        check_field("send_valid", 16'(want.send_valid), 16'(got.send_valid));
        check_field("send_data",  16'(want.send_data),  16'(got.send_data));
        check_field("tx_taken",   16'(want.tx_taken),   16'(got.tx_taken));
        check_field("start_ctl",  16'(want.start_ctl),  16'(got.start_ctl));
        check_field("stop_set",   16'(want.stop_set),   16'(got.stop_set));
        check_field("ack_ctl",    16'(want.ack_ctl),    16'(got.ack_ctl));
        check_field("clear_irq",  16'(want.clear_irq),  16'(got.clear_irq));
        check_field("rx_valid",   16'(want.rx_valid),   16'(got.rx_valid));
        check_field("rx_data",    16'(want.rx_data),    16'(got.rx_data));
        check_field("op_done",    16'(want.op_done),    16'(got.op_done));
        check_field("unexpected", 16'(want.unexpected), 16'(got.unexpected));
      end
    end
  end

endmodule
